FILE: rtl/cpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg - shared types and helpers for the closest-point-on-triangle block
// Widths follow from the coordinate width; arithmetic helpers keep each
// product at its exact size.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int CW    = 20;            // coordinate, signed Q10.10
	localparam int EW    = CW + 1;        // vertex/point difference
	localparam int GW    = 2 * EW + 2;    // dot product of differences
	localparam int HW    = GW / 2;        // split point of a Gram operand
	localparam int PW    = GW + HW + 1;   // partial product
	localparam int KW    = 2 * GW;        // determinant and face weights
	localparam int SW    = KW / 2;        // split point of a face weight
	localparam int NW    = KW + EW + 1;   // projection numerator
	localparam int RW    = NW + 1;        // divider remainder
	localparam int QB    = CW + 2;        // quotient magnitude bits
	localparam int QW    = QB + 1;        // signed quotient
	localparam int DW    = 2 * CW + 4;    // squared distance, Q24.20
	localparam int NLANE = 12;            // face x/y/z, then x/y/z for edge 01, 02, 12
	localparam int DLAT  = QB + 1;        // divider register stages

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EW-1:0] diff_t;
	typedef logic signed [GW-1:0] gram_t;
	typedef logic signed [PW-1:0] part_t;
	typedef logic signed [KW-1:0] kdet_t;
	typedef logic signed [NW-1:0] num_t;
	typedef logic signed [QW-1:0] quo_t;
	typedef logic [DW-1:0]        dist_t;
	typedef coord_t [2:0]         cvec_t;
	typedef diff_t [2:0]          dvec_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t vert0_x;
		coord_t vert0_y;
		coord_t vert0_z;
		coord_t vert1_x;
		coord_t vert1_y;
		coord_t vert1_z;
		coord_t vert2_x;
		coord_t vert2_y;
		coord_t vert2_z;
	} req_t;

	typedef struct packed {
		dist_t  dist_sq;
		coord_t near_x;
		coord_t near_y;
		coord_t near_z;
	} rsp_t;

	function automatic diff_t sub_d(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic gram_t dot3(dvec_t a, dvec_t b);
		diff_t ak;
		diff_t bk;
		logic signed [2*EW-1:0] pr;
		gram_t acc;
		acc = '0;
		for (int k = 0; k < 3; k++) begin
			ak  = a[k];
			bk  = b[k];
			pr  = ak * bk;
			acc = acc + gram_t'(pr);
		end
		return acc;
	endfunction

	// x times the low / high half of y
	function automatic part_t plo(gram_t x, gram_t y);
		logic signed [HW:0] yl;
		part_t r;
		yl = $signed({1'b0, y[HW-1:0]});
		r  = x * yl;
		return r;
	endfunction

	function automatic part_t phi(gram_t x, gram_t y);
		logic signed [GW-HW-1:0] yh;
		part_t r;
		yh = $signed(y[GW-1:HW]);
		r  = x * yh;
		return r;
	endfunction

	function automatic part_t slo(kdet_t s, diff_t e);
		logic signed [SW:0] sl;
		part_t r;
		sl = $signed({1'b0, s[SW-1:0]});
		r  = sl * e;
		return r;
	endfunction

	function automatic part_t shi(kdet_t s, diff_t e);
		logic signed [KW-SW-1:0] sh;
		part_t r;
		sh = $signed(s[KW-1:SW]);
		r  = sh * e;
		return r;
	endfunction

	function automatic kdet_t join_k(part_t lo, part_t hi);
		return (kdet_t'(hi) <<< HW) + kdet_t'(lo);
	endfunction

	function automatic num_t join_n(part_t lo, part_t hi);
		return (num_t'(hi) <<< SW) + num_t'(lo);
	endfunction

	function automatic num_t emul(gram_t r, diff_t e);
		logic signed [GW+EW-1:0] p;
		p = r * e;
		return num_t'(p);
	endfunction

endpackage

FILE: rtl/cpt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_req_if - query channel
// Valid/ready handshake carrying one query point and triangle.
// ----------------------------------------------------------------------------
interface cpt_req_if;
	logic          valid;
	logic          ready;
	cpt_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/cpt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_rsp_if - result channel
// Valid/ready handshake carrying the nearest point and squared distance.
// ----------------------------------------------------------------------------
interface cpt_rsp_if;
	logic          valid;
	logic          ready;
	cpt_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/cpt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_div - pipelined rounding divider
// Signed numerator over positive denominator, rounded to nearest with ties
// away from zero; one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpt_div (
	input  logic           clk,
	input  logic           en,
	input  cpt_pkg::num_t  num,
	input  cpt_pkg::kdet_t den,
	output cpt_pkg::quo_t  q
);

	logic                         neg_s [cpt_pkg::QB+1];
	logic [cpt_pkg::RW-1:0]       rem_s [cpt_pkg::QB+1];
	logic [cpt_pkg::KW:0]         dd_s  [cpt_pkg::QB+1];
	logic [cpt_pkg::QB-1:0]       q_s   [cpt_pkg::QB+1];
	cpt_pkg::num_t                mag;

	// round(|n|/d) = floor((2|n| + d) / 2d)
	assign mag = num[cpt_pkg::NW-1] ? -num : num;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[cpt_pkg::NW-1];
			rem_s[0] <= {mag, 1'b0} + cpt_pkg::RW'($unsigned(den));
			dd_s[0]  <= {$unsigned(den), 1'b0};
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < cpt_pkg::QB; j++) begin : g_bit
		logic [cpt_pkg::RW:0]   trial;
		logic [cpt_pkg::QB-1:0] qbit;
		assign trial = {1'b0, rem_s[j]}
			- ((cpt_pkg::RW+1)'(dd_s[j]) << (cpt_pkg::QB - 1 - j));
		assign qbit  = cpt_pkg::QB'(!trial[cpt_pkg::RW]) << (cpt_pkg::QB - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[j+1] <= neg_s[j];
				dd_s[j+1]  <= dd_s[j];
				rem_s[j+1] <= trial[cpt_pkg::RW] ? rem_s[j] : trial[cpt_pkg::RW-1:0];
				q_s[j+1]   <= q_s[j] | qbit;
			end
		end
	end

	assign q = neg_s[cpt_pkg::QB] ? -cpt_pkg::quo_t'({1'b0, q_s[cpt_pkg::QB]})
	                              : cpt_pkg::quo_t'({1'b0, q_s[cpt_pkg::QB]});

endmodule

FILE: rtl/closest_point_on_triangle_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_triangle_3d - nearest point of a triangle to a query point
// Streams point/triangle requests, returns nearest point and squared distance.
// ----------------------------------------------------------------------------
// One request per clock unless rsp stalls, fully pipelined: front-end
// stages form the edge vectors, Gram terms, determinant and projection
// numerators, twelve rounding dividers run side by side (a quotient bit
// each stage; face, edge 01/02/12 lanes x/y/z), back-end stages square the
// candidate offsets and pick the winner. The last stage is the output
// register; a stall on rsp freezes the whole pipe, nothing is dropped.
// Candidates: V0, V1, V2, face, edge 01, edge 02, edge 12; an earlier one
// wins ties. All math is exact integer (Cramer's rule on the Gram system),
// projected coordinates round to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_3d (
	input  logic      clk,
	input  logic      arst_n,
	cpt_req_if.sink   req,
	cpt_rsp_if.source rsp
);

	// front-end work, carried stage to stage
	typedef struct packed {
		cpt_pkg::cvec_t                       v0, v1, v2;
		cpt_pkg::dvec_t                       e1, e2, e12, d0, d1, d2;
		cpt_pkg::gram_t                       ga, gb, gc, r1, r2, a12, r12;
		cpt_pkg::dist_t                       dv0, dv1, dv2, bd;
		cpt_pkg::cvec_t                       bp;
		logic                                 ok01, ok02, ok12, fok;
		cpt_pkg::part_t [11:0]                pp;
		cpt_pkg::kdet_t                       det, s, t;
		cpt_pkg::part_t [11:0]                fp;
		cpt_pkg::num_t  [cpt_pkg::NLANE-1:0]  num;
		cpt_pkg::kdet_t [cpt_pkg::NLANE-1:0]  den;
	} pipe_t;

	// what rides alongside the dividers
	typedef struct packed {
		cpt_pkg::dist_t bd;
		cpt_pkg::cvec_t bp;
		logic           fok, ok01, ok02, ok12;
		cpt_pkg::dvec_t d0, d1;
		cpt_pkg::cvec_t v0, v1;
	} side_t;

	// back end: four projected candidates plus best vertex
	typedef struct packed {
		cpt_pkg::dist_t [3:0] cd;
		cpt_pkg::cvec_t [3:0] cp;
		logic [3:0]           ok;
		cpt_pkg::dist_t       bd;
		cpt_pkg::cvec_t       bp;
	} fin_t;

	logic  adv;
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic  vld_dly_q [cpt_pkg::DLAT];
	pipe_t n1, n2, n3, n4, n5, n6;
	pipe_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	side_t side_q [cpt_pkg::DLAT];
	fin_t  n7, n8, n9, st_s7, st_s8, st_s9;
	cpt_pkg::quo_t quo [cpt_pkg::NLANE];

	// whole pipe moves unless the output holds a result nobody takes
	assign adv       = !vld_s9 || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = vld_s9;
	assign rsp.data  = '{dist_sq: st_s9.bd, near_x: st_s9.bp[0],
	                     near_y: st_s9.bp[1], near_z: st_s9.bp[2]};

	// stage 1: differences
	always_comb begin
		cpt_pkg::cvec_t pt;
		n1    = '0;
		pt    = {req.data.point_z, req.data.point_y, req.data.point_x};
		n1.v0 = {req.data.vert0_z, req.data.vert0_y, req.data.vert0_x};
		n1.v1 = {req.data.vert1_z, req.data.vert1_y, req.data.vert1_x};
		n1.v2 = {req.data.vert2_z, req.data.vert2_y, req.data.vert2_x};
		for (int k = 0; k < 3; k++) begin
			n1.e1[k]  = cpt_pkg::sub_d(n1.v1[k], n1.v0[k]);
			n1.e2[k]  = cpt_pkg::sub_d(n1.v2[k], n1.v0[k]);
			n1.e12[k] = cpt_pkg::sub_d(n1.v2[k], n1.v1[k]);
			n1.d0[k]  = cpt_pkg::sub_d(pt[k], n1.v0[k]);
			n1.d1[k]  = cpt_pkg::sub_d(pt[k], n1.v1[k]);
			n1.d2[k]  = cpt_pkg::sub_d(pt[k], n1.v2[k]);
		end
	end

	// stage 2: Gram terms and vertex distances
	always_comb begin
		n2     = st_s1;
		n2.ga  = cpt_pkg::dot3(st_s1.e1, st_s1.e1);
		n2.gb  = cpt_pkg::dot3(st_s1.e1, st_s1.e2);
		n2.gc  = cpt_pkg::dot3(st_s1.e2, st_s1.e2);
		n2.r1  = cpt_pkg::dot3(st_s1.e1, st_s1.d0);
		n2.r2  = cpt_pkg::dot3(st_s1.e2, st_s1.d0);
		n2.a12 = cpt_pkg::dot3(st_s1.e12, st_s1.e12);
		n2.r12 = cpt_pkg::dot3(st_s1.e12, st_s1.d1);
		n2.dv0 = cpt_pkg::dist_t'(cpt_pkg::dot3(st_s1.d0, st_s1.d0));
		n2.dv1 = cpt_pkg::dist_t'(cpt_pkg::dot3(st_s1.d1, st_s1.d1));
		n2.dv2 = cpt_pkg::dist_t'(cpt_pkg::dot3(st_s1.d2, st_s1.d2));
	end

	// stage 3: best vertex, edge tests and numerators, face partial products
	always_comb begin
		n3    = st_s2;
		n3.bd = st_s2.dv0;
		n3.bp = st_s2.v0;
		if (st_s2.dv1 < n3.bd) begin
			n3.bd = st_s2.dv1;
			n3.bp = st_s2.v1;
		end
		if (st_s2.dv2 < n3.bd) begin
			n3.bd = st_s2.dv2;
			n3.bp = st_s2.v2;
		end
		n3.ok01 = (st_s2.ga > 0) && (st_s2.r1 >= 0) && (st_s2.r1 <= st_s2.ga);
		n3.ok02 = (st_s2.gc > 0) && (st_s2.r2 >= 0) && (st_s2.r2 <= st_s2.gc);
		n3.ok12 = (st_s2.a12 > 0) && (st_s2.r12 >= 0) && (st_s2.r12 <= st_s2.a12);
		for (int k = 0; k < 3; k++) begin
			n3.num[3+k] = cpt_pkg::emul(st_s2.r1, st_s2.e1[k]);
			n3.num[6+k] = cpt_pkg::emul(st_s2.r2, st_s2.e2[k]);
			n3.num[9+k] = cpt_pkg::emul(st_s2.r12, st_s2.e12[k]);
			n3.den[3+k] = cpt_pkg::kdet_t'(st_s2.ga);
			n3.den[6+k] = cpt_pkg::kdet_t'(st_s2.gc);
			n3.den[9+k] = cpt_pkg::kdet_t'(st_s2.a12);
		end
		n3.pp[0]  = cpt_pkg::plo(st_s2.ga, st_s2.gc);
		n3.pp[1]  = cpt_pkg::phi(st_s2.ga, st_s2.gc);
		n3.pp[2]  = cpt_pkg::plo(st_s2.gb, st_s2.gb);
		n3.pp[3]  = cpt_pkg::phi(st_s2.gb, st_s2.gb);
		n3.pp[4]  = cpt_pkg::plo(st_s2.gc, st_s2.r1);
		n3.pp[5]  = cpt_pkg::phi(st_s2.gc, st_s2.r1);
		n3.pp[6]  = cpt_pkg::plo(st_s2.gb, st_s2.r2);
		n3.pp[7]  = cpt_pkg::phi(st_s2.gb, st_s2.r2);
		n3.pp[8]  = cpt_pkg::plo(st_s2.ga, st_s2.r2);
		n3.pp[9]  = cpt_pkg::phi(st_s2.ga, st_s2.r2);
		n3.pp[10] = cpt_pkg::plo(st_s2.gb, st_s2.r1);
		n3.pp[11] = cpt_pkg::phi(st_s2.gb, st_s2.r1);
	end

	// stage 4: determinant and unnormalized face weights
	always_comb begin
		n4     = st_s3;
		n4.det = cpt_pkg::join_k(st_s3.pp[0], st_s3.pp[1])
		       - cpt_pkg::join_k(st_s3.pp[2], st_s3.pp[3]);
		n4.s   = cpt_pkg::join_k(st_s3.pp[4], st_s3.pp[5])
		       - cpt_pkg::join_k(st_s3.pp[6], st_s3.pp[7]);
		n4.t   = cpt_pkg::join_k(st_s3.pp[8], st_s3.pp[9])
		       - cpt_pkg::join_k(st_s3.pp[10], st_s3.pp[11]);
	end

	// stage 5: face inside test, numerator partial products
	always_comb begin
		logic signed [cpt_pkg::KW:0] wsum;
		n5     = st_s4;
		wsum   = (cpt_pkg::KW+1)'(st_s4.s) + (cpt_pkg::KW+1)'(st_s4.t);
		n5.fok = (st_s4.det > 0) && (st_s4.s >= 0) && (st_s4.t >= 0)
		      && (wsum <= (cpt_pkg::KW+1)'(st_s4.det));
		for (int k = 0; k < 3; k++) begin
			n5.fp[4*k]   = cpt_pkg::slo(st_s4.s, st_s4.e1[k]);
			n5.fp[4*k+1] = cpt_pkg::shi(st_s4.s, st_s4.e1[k]);
			n5.fp[4*k+2] = cpt_pkg::slo(st_s4.t, st_s4.e2[k]);
			n5.fp[4*k+3] = cpt_pkg::shi(st_s4.t, st_s4.e2[k]);
			n5.den[k]    = st_s4.det;
		end
	end

	// stage 6: face numerators s*e1 + t*e2
	always_comb begin
		n6 = st_s5;
		for (int k = 0; k < 3; k++) begin
			n6.num[k] = cpt_pkg::join_n(st_s5.fp[4*k], st_s5.fp[4*k+1])
			          + cpt_pkg::join_n(st_s5.fp[4*k+2], st_s5.fp[4*k+3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= n1;
			st_s2 <= n2;
			st_s3 <= n3;
			st_s4 <= n4;
			st_s5 <= n5;
			st_s6 <= n6;
		end
	end

	// dividers: face lanes first, then edge 01, edge 02, edge 12, x/y/z each
	for (genvar l = 0; l < cpt_pkg::NLANE; l++) begin : g_lane
		cpt_div u_div (
			.clk (clk),
			.en  (adv),
			.num (st_s6.num[l]),
			.den (st_s6.den[l]),
			.q   (quo[l])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= '{bd: st_s6.bd, bp: st_s6.bp, fok: st_s6.fok,
			               ok01: st_s6.ok01, ok02: st_s6.ok02, ok12: st_s6.ok12,
			               d0: st_s6.d0, d1: st_s6.d1, v0: st_s6.v0, v1: st_s6.v1};
			for (int j = 1; j < cpt_pkg::DLAT; j++)
				side_q[j] <= side_q[j-1];
		end
	end

	// stage 7: candidate points and their squared distances
	always_comb begin
		side_t                          sd;
		cpt_pkg::cvec_t                 vb;
		cpt_pkg::dvec_t                 db;
		cpt_pkg::quo_t                  qk;
		cpt_pkg::coord_t                vk;
		cpt_pkg::diff_t                 dk;
		logic signed [cpt_pkg::QW:0]    df;
		logic signed [2*cpt_pkg::QW+1:0] sq;
		logic signed [2*cpt_pkg::QW+3:0] acc;
		cpt_pkg::quo_t                  cs;
		sd    = side_q[cpt_pkg::DLAT-1];
		n7    = '0;
		n7.bd = sd.bd;
		n7.bp = sd.bp;
		n7.ok = {sd.ok12, sd.ok02, sd.ok01, sd.fok};
		for (int c = 0; c < 4; c++) begin
			// edge 12 hangs off V1, the rest off V0
			vb  = (c == 3) ? sd.v1 : sd.v0;
			db  = (c == 3) ? sd.d1 : sd.d0;
			acc = '0;
			for (int k = 0; k < 3; k++) begin
				qk  = quo[3*c+k];
				vk  = vb[k];
				dk  = db[k];
				df  = (cpt_pkg::QW+1)'(qk) - (cpt_pkg::QW+1)'(dk);
				sq  = df * df;
				acc = acc + (2*cpt_pkg::QW+4)'(sq);
				cs  = qk + cpt_pkg::quo_t'(vk);
				n7.cp[c][k] = cs[cpt_pkg::CW-1:0];
			end
			n7.cd[c] = acc[cpt_pkg::DW-1:0];
		end
	end

	// stages 8 and 9: strict-less selection in candidate order
	always_comb begin
		n8 = st_s7;
		for (int c = 0; c < 2; c++) begin
			if (n8.ok[c] && (n8.cd[c] < n8.bd)) begin
				n8.bd = n8.cd[c];
				n8.bp = n8.cp[c];
			end
		end
	end

	always_comb begin
		n9 = st_s8;
		for (int c = 2; c < 4; c++) begin
			if (n9.ok[c] && (n9.cd[c] < n9.bd)) begin
				n9.bd = n9.cd[c];
				n9.bp = n9.cp[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s7 <= n7;
			st_s8 <= n8;
			st_s9 <= n9;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			for (int j = 0; j < cpt_pkg::DLAT; j++)
				vld_dly_q[j] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_dly_q[0] <= vld_s6;
			for (int j = 1; j < cpt_pkg::DLAT; j++)
				vld_dly_q[j] <= vld_dly_q[j-1];
			vld_s7 <= vld_dly_q[cpt_pkg::DLAT-1];
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

endmodule
